FILE: rtl/core/blfp_pkg.sv
// Package for the backlight fade and PWM reload unit: widths, codes, reset values, structs.
// Stands alone; every other file in rtl/core refers to it by scoped names.
package blfp_pkg;

    localparam int RELOAD_WIDTH  = 16;
    localparam int COMPARE_WIDTH = RELOAD_WIDTH - 1;
    localparam int LEVEL_W       = 8;
    localparam int STEP_W        = 8;
    localparam int CLOCK_W       = 32;
    localparam int PRESCALE_W    = 16;
    localparam int PRODUCT_W     = LEVEL_W + PRESCALE_W;
    localparam int OPCODE_W      = 2;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;

    // One multiplier bit and one quotient bit per cycle
    localparam int MUL_STEPS = LEVEL_W;
    localparam int DIV_STEPS = CLOCK_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0]      LEVEL_FULL = 8'hFF;
    localparam logic [LEVEL_W-1:0]      LEVEL_OFF  = 8'h00;
    localparam logic [RELOAD_WIDTH-1:0] RELOAD_MAX = '1;

    localparam logic [LEVEL_W-1:0]    RST_TARGET_LEVEL = 8'd255;
    localparam logic [STEP_W-1:0]     RST_STEP_SIZE    = 8'd0;
    localparam logic                  RST_FADE_UP      = 1'b0;
    localparam logic [CLOCK_W-1:0]    RST_CORE_CLOCK   = 32'd72000000;
    localparam logic [PRESCALE_W-1:0] RST_PRESCALE     = 16'd18;
    localparam logic [LEVEL_W-1:0]    RST_LEVEL        = 8'd255;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_LEVEL  = 2'd1,
        OP_START_FADE = 2'd2
    } blfp_op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_LEVEL   = 3'd0,
        CFG_STEP_SIZE      = 3'd1,
        CFG_FADE_UP        = 3'd2,
        CFG_CORE_CLOCK     = 3'd3,
        CFG_TIMER_PRESCALE = 3'd4
    } blfp_cfg_idx_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_HOLD
    } blfp_seq_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               fading;
    } blfp_fade_st_t;

    typedef struct packed {
        logic [CLOCK_W-1:0]    clock_hz;
        logic [PRESCALE_W-1:0] prescale;
    } blfp_timer_cfg_t;

endpackage

FILE: rtl/core/blfp_ifs.sv
// Handshake channels of the backlight fade unit: item request, result and register write.
// Depends on blfp_pkg for field widths.
interface blfp_item_if;
    logic                               valid;
    logic                               ready;
    logic [blfp_pkg::OPCODE_W-1:0]      opcode;
    logic [blfp_pkg::LEVEL_W-1:0]       new_level;

    modport source (output valid, opcode, new_level, input ready);
    modport sink   (input valid, opcode, new_level, output ready);
endinterface

interface blfp_result_if;
    logic                                valid;
    logic                                ready;
    logic [blfp_pkg::LEVEL_W-1:0]        level;
    logic [blfp_pkg::RELOAD_WIDTH-1:0]   reload;
    logic [blfp_pkg::COMPARE_WIDTH-1:0]  compare;
    logic                                fading;
    logic                                fault;

    modport source (output valid, level, reload, compare, fading, fault, input ready);
    modport sink   (input valid, level, reload, compare, fading, fault, output ready);
endinterface

interface blfp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [blfp_pkg::CFG_INDEX_W-1:0]   index;
    logic [blfp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/backlight_fade_pwm_reload_unit.sv
// Backlight fade engine with PWM timer reload: one result per request, one request at a time.
// From accepted request to valid result: a load state, 8 serial multiply steps
// (level x prescaler), 32 serial divide steps (clock / product), then the hand-over.
// A new request is taken only once the last result is handed over; a result not yet taken
// when the next one finishes holds the engine and stalls further requests. Reset (rst_n,
// async low) restores the register defaults, level 255, fade off, and empties the output.
module backlight_fade_pwm_reload_unit (
    input  logic            clk,
    input  logic            rst_n,
    blfp_item_if.sink       item,
    blfp_result_if.source   result,
    blfp_cfg_if.sink        cfg
);

    blfp_pkg::blfp_seq_t        seq_reg, seq_next;
    blfp_pkg::blfp_fade_st_t    fade_st;
    blfp_pkg::blfp_timer_cfg_t  timer_cfg;

    logic                                   fire;
    logic                                   mul_start, mul_done;
    logic                                   div_start, div_done;
    logic                                   load_out;
    logic [blfp_pkg::PRODUCT_W-1:0]         product;
    logic [blfp_pkg::CLOCK_W-1:0]           quotient;
    logic [blfp_pkg::CLOCK_W-1:0]           q_minus1;
    logic [blfp_pkg::RELOAD_WIDTH-1:0]      reload_calc;
    logic                                   fault_calc;

    logic                                   out_valid_reg;
    logic [blfp_pkg::LEVEL_W-1:0]           level_reg;
    logic [blfp_pkg::RELOAD_WIDTH-1:0]      reload_reg;
    logic                                   fading_reg;
    logic                                   fault_reg;

    // Request accepted only when the engine is free; the output register may still be full
    assign item.ready = (seq_reg == blfp_pkg::SEQ_IDLE);
    assign fire       = item.valid && item.ready;

    // Configuration and fade state; the level updates at the accepting edge
    blfp_fade u_fade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .opcode    (item.opcode),
        .new_level (item.new_level),
        .fade_st   (fade_st),
        .timer_cfg (timer_cfg)
    );

    // Divisor: level times prescaler, LSB of level first
    blfp_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (timer_cfg.prescale),
        .mplier  (fade_st.level),
        .done    (mul_done),
        .product (product)
    );

    // Quotient: core clock over the divisor, MSB first
    blfp_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (timer_cfg.clock_hz),
        .divisor  (product),
        .done     (div_done),
        .quotient (quotient)
    );

    // Next state of the sequencer
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            blfp_pkg::SEQ_IDLE: if (fire)     seq_next = blfp_pkg::SEQ_LOAD;
            blfp_pkg::SEQ_LOAD:               seq_next = blfp_pkg::SEQ_MUL;
            blfp_pkg::SEQ_MUL:  if (mul_done) seq_next = blfp_pkg::SEQ_DIV;
            blfp_pkg::SEQ_DIV:
            begin
                if (div_done)
                    seq_next = load_out ? blfp_pkg::SEQ_IDLE : blfp_pkg::SEQ_HOLD;
            end
            blfp_pkg::SEQ_HOLD: if (load_out) seq_next = blfp_pkg::SEQ_IDLE;
            default:                          seq_next = blfp_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: start pulses and the hand-over into the output register
    always_comb
    begin
        mul_start = (seq_reg == blfp_pkg::SEQ_LOAD);
        div_start = (seq_reg == blfp_pkg::SEQ_MUL) && mul_done;
        load_out  = (((seq_reg == blfp_pkg::SEQ_DIV) && div_done) ||
                     (seq_reg == blfp_pkg::SEQ_HOLD)) &&
                    (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= blfp_pkg::SEQ_IDLE;
        else
            seq_reg <= seq_next;
    end

    // Clamp the reload: zero divisor saturates high, zero quotient floors at 0,
    // a quotient past the reload range saturates high; all three flag a fault.
    // Divider and multiplier hold their results until the next start.
    assign q_minus1 = quotient - 1'b1;

    always_comb
    begin
        reload_calc = q_minus1[blfp_pkg::RELOAD_WIDTH-1:0];
        fault_calc  = 1'b0;
        if (product == '0)
        begin
            reload_calc = blfp_pkg::RELOAD_MAX;
            fault_calc  = 1'b1;
        end
        else if (quotient == '0)
        begin
            reload_calc = '0;
            fault_calc  = 1'b1;
        end
        else if (q_minus1 > {{(blfp_pkg::CLOCK_W-blfp_pkg::RELOAD_WIDTH){1'b0}},
                             blfp_pkg::RELOAD_MAX})
        begin
            reload_calc = blfp_pkg::RELOAD_MAX;
            fault_calc  = 1'b1;
        end
    end

    // Output register: fill on hand-over, drop the valid once the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            level_reg  <= fade_st.level;
            reload_reg <= reload_calc;
            fading_reg <= fade_st.fading;
            fault_reg  <= fault_calc;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.level   = level_reg;
    assign result.reload  = reload_reg;
    assign result.compare = reload_reg[blfp_pkg::RELOAD_WIDTH-1:1];
    assign result.fading  = fading_reg;
    assign result.fault   = fault_reg;

    // A finished multiply only ever lands while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (seq_reg == blfp_pkg::SEQ_MUL))
        else $error("multiplier finished outside its phase");

    // Same for the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (seq_reg == blfp_pkg::SEQ_DIV))
        else $error("divider finished outside its phase");

    // Holding a result is only legal while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == blfp_pkg::SEQ_HOLD) |-> out_valid_reg)
        else $error("result held with an empty output register");

    // An accepted request always starts the multiply on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> mul_start)
        else $error("accepted request did not start the multiplier");

endmodule

FILE: rtl/core/blfp_fade.sv
// Configuration registers and the level / fade state of the backlight fade unit.
// Depends on blfp_pkg and blfp_cfg_if.
module blfp_fade (
    input  logic                             clk,
    input  logic                             rst_n,
    blfp_cfg_if.sink                         cfg,
    input  logic                             fire,
    input  logic [blfp_pkg::OPCODE_W-1:0]    opcode,
    input  logic [blfp_pkg::LEVEL_W-1:0]     new_level,
    output blfp_pkg::blfp_fade_st_t          fade_st,
    output blfp_pkg::blfp_timer_cfg_t        timer_cfg
);

    logic [blfp_pkg::LEVEL_W-1:0]    target_reg;
    logic [blfp_pkg::STEP_W-1:0]     step_reg;
    logic                            fade_up_reg;
    logic [blfp_pkg::CLOCK_W-1:0]    clock_reg;
    logic [blfp_pkg::PRESCALE_W-1:0] prescale_reg;
    logic [blfp_pkg::LEVEL_W-1:0]    level_reg,  level_next;
    logic                            fading_reg, fading_next;
    logic [blfp_pkg::LEVEL_W:0]      sum_up;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= blfp_pkg::RST_TARGET_LEVEL;
            step_reg     <= blfp_pkg::RST_STEP_SIZE;
            fade_up_reg  <= blfp_pkg::RST_FADE_UP;
            clock_reg    <= blfp_pkg::RST_CORE_CLOCK;
            prescale_reg <= blfp_pkg::RST_PRESCALE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                blfp_pkg::CFG_TARGET_LEVEL:   target_reg   <= cfg.data[blfp_pkg::LEVEL_W-1:0];
                blfp_pkg::CFG_STEP_SIZE:      step_reg     <= cfg.data[blfp_pkg::STEP_W-1:0];
                blfp_pkg::CFG_FADE_UP:        fade_up_reg  <= cfg.data[0];
                blfp_pkg::CFG_CORE_CLOCK:     clock_reg    <= cfg.data[blfp_pkg::CLOCK_W-1:0];
                blfp_pkg::CFG_TIMER_PRESCALE: prescale_reg <= cfg.data[blfp_pkg::PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign sum_up = {1'b0, level_reg} + {1'b0, step_reg};

    always_comb
    begin
        level_next  = level_reg;
        fading_next = fading_reg;
        if (fire)
        begin
            case (opcode)
                blfp_pkg::OP_TICK:
                begin
                    if (fading_reg)
                    begin
                        if (fade_up_reg)
                        begin
                            if (level_reg >= target_reg)
                                fading_next = 1'b0;
                            else if (sum_up[blfp_pkg::LEVEL_W])
                            begin
                                level_next  = blfp_pkg::LEVEL_FULL;
                                fading_next = 1'b0;
                            end
                            else
                                level_next = sum_up[blfp_pkg::LEVEL_W-1:0];
                        end
                        else
                        begin
                            if (level_reg <= target_reg)
                                fading_next = 1'b0;
                            else if (level_reg < step_reg)
                            begin
                                level_next  = blfp_pkg::LEVEL_OFF;
                                fading_next = 1'b0;
                            end
                            else
                                level_next = level_reg - step_reg;
                        end
                    end
                end
                blfp_pkg::OP_SET_LEVEL:  level_next  = new_level;
                blfp_pkg::OP_START_FADE: fading_next = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= blfp_pkg::RST_LEVEL;
            fading_reg <= 1'b0;
        end
        else
        begin
            level_reg  <= level_next;
            fading_reg <= fading_next;
        end
    end

    assign fade_st.level      = level_reg;
    assign fade_st.fading     = fading_reg;
    assign timer_cfg.clock_hz = clock_reg;
    assign timer_cfg.prescale = prescale_reg;

endmodule

FILE: rtl/core/blfp_serial_mul.sv
// Bit-serial shift-and-add multiplier: level times prescaler, one level bit per cycle.
// Depends on blfp_pkg.
module blfp_serial_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [blfp_pkg::PRESCALE_W-1:0]    mcand,
    input  logic [blfp_pkg::LEVEL_W-1:0]       mplier,
    output logic                               done,
    output logic [blfp_pkg::PRODUCT_W-1:0]     product
);

    logic [blfp_pkg::PRODUCT_W-1:0] mcand_reg,  mcand_next;
    logic [blfp_pkg::PRODUCT_W-1:0] acc_reg,    acc_next;
    logic [blfp_pkg::LEVEL_W-1:0]   mplier_reg, mplier_next;
    logic [blfp_pkg::MUL_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                           busy_reg,   busy_next;
    logic                           done_reg,   done_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = {{(blfp_pkg::PRODUCT_W-blfp_pkg::PRESCALE_W){1'b0}}, mcand};
            mplier_next = mplier;
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == blfp_pkg::MUL_CNT_W'(blfp_pkg::MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/core/blfp_serial_div.sv
// Restoring bit-serial divider: core clock over divisor, one quotient bit per cycle.
// Depends on blfp_pkg.
module blfp_serial_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [blfp_pkg::CLOCK_W-1:0]       dividend,
    input  logic [blfp_pkg::PRODUCT_W-1:0]     divisor,
    output logic                               done,
    output logic [blfp_pkg::CLOCK_W-1:0]       quotient
);

    // Dividend bits leave at the top of q_reg while quotient bits enter at the bottom
    logic [blfp_pkg::CLOCK_W-1:0]   q_reg,    q_next;
    logic [blfp_pkg::PRODUCT_W-1:0] rem_reg,  rem_next;
    logic [blfp_pkg::PRODUCT_W-1:0] dsr_reg,  dsr_next;
    logic [blfp_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [blfp_pkg::PRODUCT_W:0]   rem_sh;
    logic [blfp_pkg::PRODUCT_W:0]   diff;
    logic                           fits;

    assign rem_sh = {rem_reg, q_reg[blfp_pkg::CLOCK_W-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign fits   = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[blfp_pkg::PRODUCT_W-1:0] : rem_sh[blfp_pkg::PRODUCT_W-1:0];
            q_next   = {q_reg[blfp_pkg::CLOCK_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == blfp_pkg::DIV_CNT_W'(blfp_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
